### rtl/core/rms_peak_level_meter_core_defines.svh
// Assertion macros used by the checker of the level meter.
`ifndef RMS_PEAK_LEVEL_METER_CORE_DEFINES_SVH
`define RMS_PEAK_LEVEL_METER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("level meter check failed");

// The consequent must hold in the cycle after the antecedent.
`define RPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("level meter check failed");

`endif

### rtl/core/rpm_pkg.sv
`default_nettype none

package rpm_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int COEFF_FRAC_BITS = 24;
    localparam int COEFF_W         = COEFF_FRAC_BITS + 1;
    localparam int LEVEL_W         = 16;
    localparam int SQ_FULL_W       = 2 * SAMPLE_BITS;
    localparam int SQ_W            = 2 * SAMPLE_BITS - 1;
    localparam int MS_W            = SQ_W + COEFF_FRAC_BITS;
    localparam int LO_W            = 32;
    localparam int HI_W            = MS_W - LO_W;
    localparam int PROD_LO_W       = LO_W + COEFF_W;
    localparam int PROD_HI_W       = HI_W + COEFF_W;
    localparam int WHOLE_W         = MS_W - COEFF_FRAC_BITS;
    localparam int ROOT_STEPS      = (WHOLE_W + 1) / 2;
    localparam int RAD_W           = 2 * ROOT_STEPS;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COEFF_W-1:0] COEFF_RESET = COEFF_W'(1268);
    localparam logic [COEFF_W-1:0] COEFF_ONE   = COEFF_W'(1) << COEFF_FRAC_BITS;

    localparam logic ACT_SCAN  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    typedef struct packed {
        logic                          action;
        logic signed [SAMPLE_BITS-1:0] sample;
    } rpm_in_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] rms_level;
        logic [LEVEL_W-1:0] peak_level;
    } rpm_out_t;

    typedef struct packed {
        logic                   fetch;
        logic [SAMPLE_BITS-1:0] mag;
    } rpm_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_UPDATE,
        ST_ROOT,
        ST_EMIT
    } rpm_state_t;

endpackage

`default_nettype wire

### rtl/core/rpm_front.sv
`default_nettype none

module rpm_front
    import rpm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    input  wire rpm_in_t in_data,
    output logic         push_valid,
    output rpm_op_t      push_op,
    input  wire logic    queue_full
);

    logic    op_valid_reg;
    logic    op_valid_next;
    rpm_op_t op_reg;
    rpm_op_t op_next;
    logic    accept;
    logic [SAMPLE_BITS-1:0] raw;

    assign in_stall   = op_valid_reg & queue_full;
    assign accept     = in_valid & ~in_stall;
    assign push_valid = op_valid_reg;
    assign push_op    = op_reg;

    assign op_valid_next = accept | (op_valid_reg & queue_full);

    // The most negative code negates to its own bit pattern, read as unsigned.
    always_comb
    begin
        raw           = in_data.sample;
        op_next.fetch = (in_data.action == ACT_FETCH);
        op_next.mag   = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
        end
        else
        begin
            op_valid_reg <= op_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/rpm_queue.sv
`default_nettype none

module rpm_queue
    import rpm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push_valid,
    input  wire rpm_op_t push_op,
    output logic         full,
    input  wire logic    pop,
    output logic         empty,
    output rpm_op_t      head
);

    rpm_op_t                entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full    = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push_valid & ~full;
    assign do_pop  = pop & ~empty;
    assign head    = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

### rtl/core/rpm_back.sv
`default_nettype none

module rpm_back
    import rpm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [COEFF_W-1:0] coeff,
    input  wire logic               queue_empty,
    input  wire rpm_op_t            queue_head,
    output logic                    queue_pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output rpm_out_t                out_data
);

    rpm_state_t             state_reg;
    rpm_state_t             state_next;
    logic [MS_W-1:0]        ms_reg;
    logic [MS_W-1:0]        ms_next;
    logic [SAMPLE_BITS-1:0] peak_reg;
    logic [SAMPLE_BITS-1:0] peak_next;
    logic [SAMPLE_BITS-1:0] peak_snap_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic [MS_W-1:0]        diff_reg;
    logic                   sub_reg;
    logic [PROD_LO_W-1:0]   prod_lo_reg;
    logic [PROD_HI_W-1:0]   prod_hi_reg;
    logic [MS_W-1:0]        q_reg;
    logic [RAD_W-1:0]       rem_reg;
    logic [RAD_W-1:0]       root_reg;
    logic [RAD_W-1:0]       bit_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    rpm_out_t               out_data_reg;

    logic                   out_free;
    logic                   out_load;
    logic                   take;
    logic [SQ_FULL_W-1:0]   sq_full;
    logic [MS_W-1:0]        target;
    logic                   target_ge;
    logic [MS_W-1:0]        hi_part;
    logic [MS_W-1:0]        lo_part;
    logic                   round_up;
    logic [RAD_W-1:0]       trial;
    logic                   trial_fits;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = ~out_valid_reg | ~out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    state_next = queue_head.fetch ? ST_ROOT : ST_DIFF;
                end
            end
            ST_DIFF:   state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_SUM;
            ST_SUM:    state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_IDLE;
            ST_ROOT:
            begin
                if (bit_reg[0])
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        queue_pop = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   queue_pop = ~queue_empty;
            ST_EMIT:   out_load  = out_free;
            ST_DIFF, ST_MUL_LO, ST_MUL_HI, ST_SUM, ST_UPDATE, ST_ROOT:
            begin
                queue_pop = 1'b0;
            end
        endcase
    end

    assign take = queue_pop;

    always_comb
    begin
        sq_full    = SQ_FULL_W'(queue_head.mag) * SQ_FULL_W'(queue_head.mag);
        target     = {sq_reg, {COEFF_FRAC_BITS{1'b0}}};
        target_ge  = (target >= ms_reg);
        hi_part    = MS_W'({prod_hi_reg, {(LO_W - COEFF_FRAC_BITS){1'b0}}});
        lo_part    = MS_W'(prod_lo_reg[PROD_LO_W-1:COEFF_FRAC_BITS]);
        round_up   = sub_reg & (|prod_lo_reg[COEFF_FRAC_BITS-1:0]);
        trial      = root_reg + bit_reg;
        trial_fits = (rem_reg >= trial);
    end

    always_comb
    begin
        ms_next   = ms_reg;
        peak_next = peak_reg;
        if (take)
        begin
            if (queue_head.fetch)
            begin
                peak_next = '0;
            end
            else if (queue_head.mag > peak_reg)
            begin
                peak_next = queue_head.mag;
            end
        end
        if (state_reg == ST_UPDATE)
        begin
            ms_next = sub_reg ? (ms_reg - q_reg) : (ms_reg + q_reg);
        end
    end

    assign out_valid_next = out_load | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ms_reg        <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ms_reg        <= ms_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sq_reg        <= SQ_W'(sq_full);
            peak_snap_reg <= peak_reg;
            rem_reg       <= RAD_W'(ms_reg[MS_W-1:COEFF_FRAC_BITS]);
            root_reg      <= '0;
            bit_reg       <= RAD_W'(1) << (RAD_W - 2);
        end
        else if (state_reg == ST_ROOT)
        begin
            if (trial_fits)
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (state_reg == ST_DIFF)
        begin
            diff_reg <= target_ge ? (target - ms_reg) : (ms_reg - target);
            sub_reg  <= ~target_ge;
        end
        if (state_reg == ST_MUL_LO)
        begin
            prod_lo_reg <= PROD_LO_W'(diff_reg[LO_W-1:0]) * PROD_LO_W'(coeff);
        end
        if (state_reg == ST_MUL_HI)
        begin
            prod_hi_reg <= PROD_HI_W'(diff_reg[MS_W-1:LO_W]) * PROD_HI_W'(coeff);
        end
        if (state_reg == ST_SUM)
        begin
            q_reg <= hi_part + lo_part + MS_W'(round_up);
        end
        if (out_load)
        begin
            out_data_reg.rms_level  <= LEVEL_W'(root_reg);
            out_data_reg.peak_level <= LEVEL_W'(peak_snap_reg);
        end
    end

endmodule

`default_nettype wire

### rtl/core/rms_peak_level_meter_core.sv
//  channel   direction  handshake            beat
//  in        input      in_valid / in_stall  rpm_in_t: action, sample
//  out       output     out_valid / out_stall rpm_out_t: rms_level, peak_level
//  cfg       input      cfg_valid / cfg_ready smoothing coefficient, 25 bits
//  A scan beat walks idle, diff, mul_lo, mul_hi, sum, update; the product is
//  formed in two steps, a 32 by 25 bit and a 23 by 25 bit multiply.
//  A fetch beat walks idle, root and emit; the square root yields one bit per cycle.
//  A front register and a two-entry queue take beats while the back end works.
//  Reset clears the average, the peak, the queue and the output valid flag.
`default_nettype none

module rms_peak_level_meter_core
    import rpm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire rpm_in_t            in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output rpm_out_t                out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [COEFF_W-1:0] cfg_data
);

    logic [COEFF_W-1:0] coeff_reg;
    logic [COEFF_W-1:0] coeff_next;
    logic [COEFF_W-1:0] coeff_eff;
    logic               push_valid;
    rpm_op_t            push_op;
    logic               queue_full;
    logic               queue_empty;
    logic               queue_pop;
    rpm_op_t            queue_head;

    assign cfg_ready  = 1'b1;
    assign coeff_next = (cfg_valid && cfg_ready) ? cfg_data : coeff_reg;

    // A weight above one behaves as exactly one.
    assign coeff_eff = (coeff_reg > COEFF_ONE) ? COEFF_ONE : coeff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= COEFF_RESET;
        end
        else
        begin
            coeff_reg <= coeff_next;
        end
    end

    rpm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_op    (push_op),
        .queue_full (queue_full)
    );

    rpm_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_op    (push_op),
        .full       (queue_full),
        .pop        (queue_pop),
        .empty      (queue_empty),
        .head       (queue_head)
    );

    rpm_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .coeff       (coeff_eff),
        .queue_empty (queue_empty),
        .queue_head  (queue_head),
        .queue_pop   (queue_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

`default_nettype wire

### rtl/core/rpm_checker.sv
`default_nettype none
`include "rms_peak_level_meter_core_defines.svh"

module rpm_checker
    import rpm_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire rpm_out_t           out_data
);

    // A result that waits must stay in place.
    `RPM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

    // The peak can never exceed the magnitude of the most negative sample.
    `RPM_ASSERT_SAME(a_peak_bound, clk, rst_n, out_valid, out_data.peak_level <= 16'h8000)

    // The RMS level never exceeds the magnitude of the most negative sample.
    `RPM_ASSERT_SAME(a_rms_bound, clk, rst_n, out_valid, out_data.rms_level <= 16'h8000)

    // Straight out of reset nothing is pending and the input is open.
    `RPM_ASSERT_SAME(a_reset_clean, clk, rst_n, !$past(rst_n), !out_valid && !in_stall)

endmodule

bind rms_peak_level_meter_core rpm_checker u_rpm_checker (.*);

`default_nettype wire

### dv/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rpm_pkg::*;

    localparam int SETTLE_CYCLES = 120;
    localparam int DRAIN_LIMIT   = 40000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    rpm_in_t            in_data;
    logic               out_valid;
    logic               out_stall;
    rpm_out_t           out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [COEFF_W-1:0] cfg_data;

    logic [63:0]        meter_mean_sq;
    logic [LEVEL_W-1:0] meter_peak;
    logic [COEFF_W-1:0] meter_coeff;
    rpm_out_t           levels_due[$];

    int                 fail_count;
    bit                 idle_on;
    int                 hold_request;

    rms_peak_level_meter_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic logic [LEVEL_W-1:0] root_floor(input logic [63:0] v);
        logic [31:0] r;
        logic [31:0] cand;
        r = '0;
        for (int b = 16; b >= 0; b--)
        begin
            cand = r | (32'd1 << b);
            if (64'(cand) * 64'(cand) <= v)
            begin
                r = cand;
            end
        end
        return r[LEVEL_W-1:0];
    endfunction

    task automatic predict_levels(input rpm_in_t beat);
        logic [63:0]        mag;
        logic [63:0]        target;
        logic [63:0]        step;
        logic [95:0]        prod;
        logic [COEFF_W-1:0] weight;
        rpm_out_t           levels;
        if (beat.action == ACT_FETCH)
        begin
            levels.rms_level  = root_floor(meter_mean_sq >> COEFF_FRAC_BITS);
            levels.peak_level = meter_peak;
            levels_due.push_back(levels);
            meter_peak = '0;
        end
        else
        begin
            if (beat.sample[SAMPLE_BITS-1])
            begin
                mag = (64'd1 << SAMPLE_BITS) - 64'(unsigned'(beat.sample));
            end
            else
            begin
                mag = 64'(unsigned'(beat.sample));
            end
            if (mag > 64'(meter_peak))
            begin
                meter_peak = mag[LEVEL_W-1:0];
            end
            target = (mag * mag) << COEFF_FRAC_BITS;
            weight = (meter_coeff > COEFF_ONE) ? COEFF_ONE : meter_coeff;
            if (target >= meter_mean_sq)
            begin
                prod = 96'(target - meter_mean_sq) * 96'(weight);
                meter_mean_sq = meter_mean_sq + 64'(prod >> COEFF_FRAC_BITS);
            end
            else
            begin
                prod = 96'(meter_mean_sq - target) * 96'(weight);
                step = 64'(prod >> COEFF_FRAC_BITS);
                if (prod[COEFF_FRAC_BITS-1:0] != '0)
                begin
                    step = step + 64'd1;
                end
                meter_mean_sq = meter_mean_sq - step;
            end
        end
    endtask

    task automatic send_beat(input logic act, input logic [SAMPLE_BITS-1:0] smp);
        rpm_in_t beat;
        int      gap;
        beat.action = act;
        beat.sample = smp;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
            begin
                break;
            end
        end
        predict_levels(beat);
    endtask

    task automatic settle_meter();
        @(negedge clk);
        in_valid <= 1'b0;
        for (int i = 0; i < DRAIN_LIMIT && levels_due.size() > 0; i++)
        begin
            @(posedge clk);
        end
        if (levels_due.size() > 0)
        begin
            $error("%0d expected results never arrived", levels_due.size());
            fail_count++;
            levels_due.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_coeff(input logic [COEFF_W-1:0] value);
        settle_meter();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
            begin
                break;
            end
        end
        meter_coeff = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        logic [SAMPLE_BITS-1:0] s;
        case ($urandom_range(0, 9))
            0: s = 16'h8000;
            1: s = 16'h7FFF;
            2: s = 16'($urandom_range(0, 64));
            3: s = 16'(-$urandom_range(0, 64));
            default: s = 16'($urandom);
        endcase
        return s;
    endfunction

    task automatic test_reset_state();
        send_beat(ACT_FETCH, 16'h0000);
        send_beat(ACT_SCAN, 16'd100);
        send_beat(ACT_FETCH, 16'h0000);
    endtask

    task automatic test_unity_weight();
        write_coeff(COEFF_ONE);
        send_beat(ACT_SCAN, 16'h7FFF);
        send_beat(ACT_FETCH, 16'h0000);
        send_beat(ACT_SCAN, 16'h8000);
        send_beat(ACT_FETCH, 16'hFFFF);
        send_beat(ACT_SCAN, 16'h0000);
        send_beat(ACT_FETCH, 16'h8000);
        send_beat(ACT_SCAN, 16'hFFFF);
        send_beat(ACT_SCAN, 16'h0001);
        send_beat(ACT_FETCH, 16'h5A5A);
    endtask

    task automatic test_weight_above_one();
        write_coeff(COEFF_ONE + COEFF_W'(1));
        send_beat(ACT_SCAN, 16'd1234);
        send_beat(ACT_FETCH, 16'h0000);
        write_coeff('1);
        send_beat(ACT_SCAN, 16'(-20000));
        send_beat(ACT_FETCH, 16'h0000);
    endtask

    task automatic test_weight_zero();
        write_coeff('0);
        send_beat(ACT_SCAN, 16'd300);
        send_beat(ACT_FETCH, 16'h0000);
    endtask

    task automatic test_backpressure();
        write_coeff(COEFF_W'($urandom_range(1 << 20, 1 << 24)));
        hold_request = 400;
        repeat (16)
        begin
            send_beat(($urandom_range(0, 3) == 0) ? ACT_SCAN : ACT_FETCH, pick_sample());
        end
        settle_meter();
    endtask

    task automatic run_phase(input logic [COEFF_W-1:0] weight, input int beats);
        write_coeff(weight);
        repeat (beats)
        begin
            send_beat(($urandom_range(0, 7) == 0) ? ACT_FETCH : ACT_SCAN, pick_sample());
        end
    endtask

    task automatic test_random_traffic();
        run_phase(COEFF_RESET, 100);
        run_phase(COEFF_W'($urandom_range(1, 65535)), 100);
        run_phase(COEFF_ONE, 120);
        run_phase(COEFF_W'($urandom_range(1 << 20, 1 << 24)), 150);
        run_phase(COEFF_W'($urandom_range((1 << 24) + 1, (1 << 25) - 1)), 120);
        run_phase('0, 60);
        run_phase(COEFF_W'($urandom_range(1 << 16, 1 << 22)), 150);
        idle_on = 1'b0;
        run_phase(COEFF_W'($urandom_range(1 << 18, 1 << 24)), 200);
        settle_meter();
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 12);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        rpm_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (levels_due.size() == 0)
            begin
                $error("unexpected result rms_level=%0d peak_level=%0d",
                       out_data.rms_level, out_data.peak_level);
                fail_count++;
            end
            else
            begin
                want = levels_due.pop_front();
                if (out_data.rms_level !== want.rms_level)
                begin
                    $error("rms_level expected %0d actual %0d",
                           want.rms_level, out_data.rms_level);
                    fail_count++;
                end
                if (out_data.peak_level !== want.peak_level)
                begin
                    $error("peak_level expected %0d actual %0d",
                           want.peak_level, out_data.peak_level);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("rms_peak_level_meter_core verification failed");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        idle_on       = 1'b1;
        hold_request  = 0;
        fail_count    = 0;
        meter_mean_sq = '0;
        meter_peak    = '0;
        meter_coeff   = COEFF_RESET;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_unity_weight();
        test_weight_above_one();
        test_weight_zero();
        test_backpressure();
        test_random_traffic();

        if (fail_count == 0)
        begin
            $display("rms_peak_level_meter_core verification clean");
        end
        else
        begin
            $display("rms_peak_level_meter_core verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
